>>> rtl/core/rsr_pkg.sv
package rsr_pkg;

    localparam int RequestSlots   = 16;
    localparam int MaxWays        = 8;
    localparam int MaxStripeWords = 8;
    localparam int SlotW   = 4;
    localparam int StripeW = 3;
    localparam int OffW    = 3;
    localparam int AddrW   = SlotW + StripeW + OffW;

    localparam logic [0:0] CfgWays  = 1'b0;
    localparam logic [0:0] CfgWords = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIX_RD,
        ST_FIX_WR,
        ST_OUT_RD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic             store_in;
        logic             acc_clear;
        logic             rd_en;
        logic             wr_fix;
        logic             load_out;
        logic [StripeW-1:0] stripe;
        logic [OffW-1:0]    off;
        logic             out_last;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } sts_t;

endpackage

>>> rtl/core/raid_stripe_reassembly_top.sv
// Channel | Dir | Payload
// s_      | in  | tdata: request_slot, channel_octet, word_offset, data_word; tlast: last_word
// m_      | out | tdata: out_slot, merged_word, repaired; tlast: last_of_run
// cfg_    | in  | index and 4-bit data for ways_in_use (0) and stripe_words (1)
// A repair reads each offset's surviving stripes in ST_FIX_RD, then writes the rebuilt word
// through the single store port in ST_FIX_WR; each emitted word passes ST_OUT_RD and
// ST_OUT_WAIT and waits out output stalls. Input is held off until the run ends. Synchronous
// active-low reset clears marks, configuration, output valid and state, not the stripe store.
module raid_stripe_reassembly_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // request_slot, channel_octet, word_offset, data_word
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_slot, merged_word, repaired
    output logic        m_tlast,   // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    rsr_pkg::cmd_t cmd;
    rsr_pkg::sts_t sts;
    logic [2:0] in_stripe;
    logic [3:0] run_slot;
    logic       run_repaired;

    rsr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .in_slot(s_tdata[3:0]), .in_chan(s_tdata[7:4]), .in_off(s_tdata[10:8]),
        .in_last(s_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .sts(sts), .cmd(cmd), .in_stripe(in_stripe),
        .run_slot(run_slot), .run_repaired(run_repaired)
    );

    rsr_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_slot(s_tdata[3:0]), .in_stripe(in_stripe), .in_off(s_tdata[10:8]),
        .in_data(s_tdata[74:11]),
        .run_slot(run_slot), .run_repaired(run_repaired),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );
endmodule

>>> rtl/core/rsr_datapath.sv
module rsr_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rsr_pkg::cmd_t            cmd,
    output rsr_pkg::sts_t            sts,
    input  logic [3:0]               in_slot,
    input  logic [2:0]               in_stripe,
    input  logic [2:0]               in_off,
    input  logic [63:0]              in_data,
    input  logic [3:0]               run_slot,
    input  logic                     run_repaired,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [71:0]              m_tdata,
    output logic                     m_tlast
);
    logic [63:0] mem [0:(1 << rsr_pkg::AddrW)-1];
    logic [63:0] rd_reg;
    logic [63:0] acc_reg;
    logic [rsr_pkg::AddrW-1:0] waddr, raddr;
    logic [63:0] wdata;
    logic        we;
    logic        valid_reg;
    logic [63:0] word_reg;
    logic [3:0]  slot_reg;
    logic        rep_reg, last_reg;

    assign raddr = {run_slot, cmd.stripe, cmd.off};
    assign we    = cmd.store_in | cmd.wr_fix;
    assign waddr = cmd.store_in ? {in_slot, in_stripe, in_off} : raddr;
    assign wdata = cmd.store_in ? in_data : acc_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (cmd.rd_en) rd_reg <= mem[raddr];
    end

    // Accumulator folds in each word read during a repair pass.
    always_ff @(posedge aclk) begin
        if (cmd.acc_clear) acc_reg <= '0;
        else if (cmd.rd_en) acc_reg <= acc_reg ^ mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            word_reg <= rd_reg;
            slot_reg <= run_slot;
            rep_reg  <= run_repaired;
            last_reg <= cmd.out_last;
        end
    end

    assign sts.out_busy = valid_reg && !m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, rep_reg, word_reg, slot_reg};
    assign m_tlast  = last_reg;
endmodule

>>> rtl/core/rsr_ctrl.sv
module rsr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [3:0]         in_slot,
    input  logic [3:0]         in_chan,
    input  logic [2:0]         in_off,
    input  logic               in_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [3:0]         cfg_data,
    input  rsr_pkg::sts_t      sts,
    output rsr_pkg::cmd_t      cmd,
    output logic [2:0]         in_stripe,
    output logic [3:0]         run_slot,
    output logic               run_repaired
);
    rsr_pkg::state_t state_reg, state_next;
    logic [3:0] ways_reg, words_reg;
    logic [7:0] marks_reg [0:rsr_pkg::RequestSlots-1];
    logic [3:0] slot_reg, slot_next;
    logic       rep_reg, rep_next;
    logic [2:0] miss_reg, miss_next;
    logic [2:0] s_reg, s_next, o_reg, o_next;
    logic       plast_reg, plast_next;
    logic [3:0] ew, ewd;
    logic [2:0] top_s, last_data, last_o;
    logic       ok, acc;
    logic [7:0] nm;
    logic [3:0] present;
    logic [2:0] missing;

    assign ew  = (ways_reg < 4'd2) ? 4'd2 : (ways_reg > 4'd8) ? 4'd8 : ways_reg;
    assign ewd = (words_reg == 4'd0) ? 4'd1 : (words_reg > 4'd8) ? 4'd8 : words_reg;
    assign top_s     = 3'(ew - 4'd1);
    assign last_data = 3'(ew - 4'd2);
    assign last_o    = 3'(ewd - 4'd1);
    assign in_stripe = 3'(in_chan - 4'd1);
    assign ok = (in_chan != 4'd0) && ((in_chan - 4'd1) < ew) && ({1'b0, in_off} < ewd);
    assign cfg_ready = 1'b1;
    assign run_slot = (state_reg == rsr_pkg::ST_IDLE) ? in_slot : slot_reg;
    assign run_repaired = rep_reg;
    assign acc = s_tvalid && s_tready;
    assign nm = marks_reg[in_slot] | (8'd1 << in_stripe);

    always_comb begin
        present = '0;
        missing = '0;
        for (int s = 0; s < rsr_pkg::MaxWays - 1; s++) begin
            if (s < int'(ew) - 1) begin
                if (nm[s]) present = present + 4'd1;
                else if (missing == 3'd0 && present == 4'(s)) missing = 3'(s);
            end
        end
        // Only one missing stripe matters for repair; find lowest unmarked.
        for (int s = rsr_pkg::MaxWays - 2; s >= 0; s--) begin
            if (s < int'(ew) - 1 && !nm[s]) missing = 3'(s);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ways_reg  <= 4'd4;
            words_reg <= 4'd8;
            for (int i = 0; i < rsr_pkg::RequestSlots; i++) marks_reg[i] <= '0;
        end else begin
            if (cfg_valid && cfg_index == {3'b0, rsr_pkg::CfgWays}) ways_reg <= cfg_data;
            if (cfg_valid && cfg_index == {3'b0, rsr_pkg::CfgWords}) words_reg <= cfg_data;
            if (acc && ok && in_last) marks_reg[in_slot] <= nm;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        slot_reg  <= slot_next;
        rep_reg   <= rep_next;
        miss_reg  <= miss_next;
        s_reg     <= s_next;
        o_reg     <= o_next;
        plast_reg <= plast_next;
    end

    always_comb begin
        state_next = state_reg;
        slot_next = slot_reg;
        rep_next = rep_reg;
        miss_next = miss_reg;
        s_next = s_reg;
        o_next = o_reg;
        plast_next = plast_reg;
        s_tready = 1'b0;
        cmd = '0;
        cmd.stripe = s_reg;
        cmd.off = o_reg;
        cmd.out_last = plast_reg;
        unique case (state_reg)
            rsr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && ok) begin
                    cmd.store_in = 1'b1;
                    if (in_last) begin
                        slot_next = in_slot;
                        s_next = '0;
                        o_next = '0;
                        if (present == ew - 4'd1) begin
                            rep_next = 1'b0;
                            state_next = rsr_pkg::ST_OUT_RD;
                        end else if (present == ew - 4'd2 && nm[top_s]) begin
                            rep_next = 1'b1;
                            miss_next = missing;
                            s_next = (missing == 3'd0) ? 3'd1 : 3'd0;
                            cmd.acc_clear = 1'b1;
                            state_next = rsr_pkg::ST_FIX_RD;
                        end
                    end
                end
            end
            rsr_pkg::ST_FIX_RD: begin
                cmd.rd_en = 1'b1;
                if (s_reg == top_s || (s_reg + 3'd1 == miss_reg && miss_reg == top_s)) begin
                    state_next = rsr_pkg::ST_FIX_WR;
                end else begin
                    s_next = (s_reg + 3'd1 == miss_reg) ? s_reg + 3'd2 : s_reg + 3'd1;
                end
            end
            rsr_pkg::ST_FIX_WR: begin
                cmd.wr_fix = 1'b1;
                cmd.stripe = miss_reg;
                cmd.acc_clear = 1'b1;
                s_next = (miss_reg == 3'd0) ? 3'd1 : 3'd0;
                if (o_reg == last_o) begin
                    o_next = '0;
                    s_next = '0;
                    state_next = rsr_pkg::ST_OUT_RD;
                end else begin
                    o_next = o_reg + 3'd1;
                    state_next = rsr_pkg::ST_FIX_RD;
                end
            end
            rsr_pkg::ST_OUT_RD: begin
                if (!sts.out_busy) begin
                    cmd.rd_en = 1'b1;
                    plast_next = (s_reg == last_data) && (o_reg == last_o);
                    state_next = rsr_pkg::ST_OUT_WAIT;
                end
            end
            rsr_pkg::ST_OUT_WAIT: begin
                cmd.load_out = 1'b1;
                if (plast_reg) begin
                    state_next = rsr_pkg::ST_IDLE;
                end else begin
                    if (o_reg == last_o) begin
                        o_next = '0;
                        s_next = s_reg + 3'd1;
                    end else begin
                        o_next = o_reg + 3'd1;
                    end
                    state_next = rsr_pkg::ST_OUT_RD;
                end
            end
            default: state_next = rsr_pkg::ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_tready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == rsr_pkg::ST_IDLE) else $error("ready outside idle");
    a_no_double_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.store_in && cmd.wr_fix)) else $error("two write sources");
    a_load_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> $past(cmd.rd_en)) else $error("load without read");
`endif
endmodule
